@@ rtl/core/mcet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_pkg
// Shared types and constants for the pattern cell translator: the period
// table, the command letter codes, the effect nibble codes and the result
// record that travels from the decoder to the result register.
// ----------------------------------------------------------------------------
package mcet_pkg;

	localparam int unsigned PeriodCount = 72;
	localparam int unsigned NoteBase    = 36;

	localparam logic [11:0] PERIOD_EMPTY_HI = 12'hFFF;
	localparam logic [7:0]  VOLUME_MAX      = 8'd64;
	localparam logic [7:0]  SPEED_LIMIT     = 8'd32;

	// Period table, longest period (lowest note) first.
	localparam logic [11:0] NOTE_PERIODS [PeriodCount] = '{
		12'd1712, 12'd1616, 12'd1524, 12'd1440, 12'd1356, 12'd1280,
		12'd1208, 12'd1140, 12'd1076, 12'd1016, 12'd960,  12'd907,
		12'd856,  12'd808,  12'd762,  12'd720,  12'd678,  12'd640,
		12'd604,  12'd570,  12'd538,  12'd508,  12'd480,  12'd453,
		12'd428,  12'd404,  12'd381,  12'd360,  12'd339,  12'd320,
		12'd302,  12'd285,  12'd269,  12'd254,  12'd240,  12'd226,
		12'd214,  12'd202,  12'd190,  12'd180,  12'd170,  12'd160,
		12'd151,  12'd143,  12'd135,  12'd127,  12'd120,  12'd113,
		12'd107,  12'd101,  12'd95,   12'd90,   12'd85,   12'd80,
		12'd75,   12'd71,   12'd67,   12'd63,   12'd60,   12'd56,
		12'd53,   12'd50,   12'd47,   12'd45,   12'd42,   12'd40,
		12'd37,   12'd35,   12'd33,   12'd31,   12'd30,   12'd28
	};

	// Command letters, A is 0.
	localparam logic [4:0] CMD_A = 5'd0;
	localparam logic [4:0] CMD_B = 5'd1;
	localparam logic [4:0] CMD_C = 5'd2;
	localparam logic [4:0] CMD_D = 5'd3;
	localparam logic [4:0] CMD_E = 5'd4;
	localparam logic [4:0] CMD_F = 5'd5;
	localparam logic [4:0] CMD_G = 5'd6;
	localparam logic [4:0] CMD_H = 5'd7;
	localparam logic [4:0] CMD_J = 5'd9;
	localparam logic [4:0] CMD_K = 5'd10;
	localparam logic [4:0] CMD_L = 5'd11;
	localparam logic [4:0] CMD_O = 5'd14;
	localparam logic [4:0] CMD_Q = 5'd16;
	localparam logic [4:0] CMD_R = 5'd17;
	localparam logic [4:0] CMD_S = 5'd18;
	localparam logic [4:0] CMD_T = 5'd19;
	localparam logic [4:0] CMD_X = 5'd23;

	// Effect nibbles of the cell word.
	localparam logic [3:0] EFF_ARPEGGIO   = 4'h0;
	localparam logic [3:0] EFF_PORTA_UP   = 4'h1;
	localparam logic [3:0] EFF_PORTA_DN   = 4'h2;
	localparam logic [3:0] EFF_TONE_PORTA = 4'h3;
	localparam logic [3:0] EFF_VIBRATO    = 4'h4;
	localparam logic [3:0] EFF_TP_VOLSL   = 4'h5;
	localparam logic [3:0] EFF_VIB_VOLSL  = 4'h6;
	localparam logic [3:0] EFF_TREMOLO    = 4'h7;
	localparam logic [3:0] EFF_PANNING    = 4'h8;
	localparam logic [3:0] EFF_OFFSET     = 4'h9;
	localparam logic [3:0] EFF_VOL_SLIDE  = 4'hA;
	localparam logic [3:0] EFF_JUMP       = 4'hB;
	localparam logic [3:0] EFF_VOLUME     = 4'hC;
	localparam logic [3:0] EFF_BREAK      = 4'hD;
	localparam logic [3:0] EFF_EXTENDED   = 4'hE;
	localparam logic [3:0] EFF_SPEED      = 4'hF;

	// Extended effect sub-codes (high nibble of the parameter).
	localparam logic [3:0] EXT_FILTER     = 4'h0;
	localparam logic [3:0] EXT_FINE_UP    = 4'h1;
	localparam logic [3:0] EXT_FINE_DN    = 4'h2;
	localparam logic [3:0] EXT_GLISS      = 4'h3;
	localparam logic [3:0] EXT_VIB_WAVE   = 4'h4;
	localparam logic [3:0] EXT_FINETUNE   = 4'h5;
	localparam logic [3:0] EXT_LOOP       = 4'h6;
	localparam logic [3:0] EXT_TREM_WAVE  = 4'h7;
	localparam logic [3:0] EXT_PAN        = 4'h8;
	localparam logic [3:0] EXT_RETRIG     = 4'h9;
	localparam logic [3:0] EXT_FVOL_UP    = 4'hA;
	localparam logic [3:0] EXT_FVOL_DN    = 4'hB;
	localparam logic [3:0] EXT_CUT        = 4'hC;
	localparam logic [3:0] EXT_DELAY      = 4'hD;
	localparam logic [3:0] EXT_PAT_DELAY  = 4'hE;
	localparam logic [3:0] EXT_INVERT     = 4'hF;

	localparam logic [7:0] PAR_FINE_HI  = 8'hF0;
	localparam logic [7:0] PAR_VIBWAVE  = 8'h30;
	localparam logic [7:0] PAR_LOOP     = 8'hB0;
	localparam logic [7:0] PAR_TREMWAVE = 8'h40;
	localparam logic [7:0] PAR_PATDELAY = 8'h60;

	typedef struct packed {
		logic       note_valid;
		logic [6:0] note;
		logic       instrument_valid;
		logic [7:0] instrument;
		logic       command_valid;
		logic [4:0] command;
		logic [7:0] parameter_res;
		logic       volume_valid;
		logic [6:0] volume;
	} cell_result_t;

endpackage

@@ rtl/core/mcet_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcet_decode
// Combinational translation of one pattern cell word into note, instrument,
// command, parameter and volume fields.
// ----------------------------------------------------------------------------
module mcet_decode (
	input  logic [31:0]          cell_word,
	output mcet_pkg::cell_result_t result
);
	import mcet_pkg::*;

	localparam int unsigned MidCount = PeriodCount - 1;

	logic [11:0]         period;
	logic [7:0]          sample;
	logic [3:0]          effect;
	logic [7:0]          par_in;
	logic [12:0]         period_x2;
	logic [MidCount-1:0] below_mid;
	logic [6:0]          note_idx;
	logic [7:0]          break_val;
	logic                cv;
	logic [4:0]          cmd;
	logic [7:0]          par;

	assign period    = cell_word[27:16];
	assign sample    = {cell_word[31:28], cell_word[15:12]};
	assign effect    = cell_word[11:8];
	assign par_in    = cell_word[7:0];
	assign period_x2 = {period, 1'b0};

	// Nearest entry: count the midpoints between neighbors that lie at or above
	// the period (a tie goes to the shorter period). The flags form a
	// thermometer, so the index is the position of its edge.
	always_comb begin
		for (int n = 0; n < MidCount; n++) begin
			below_mid[n] = period_x2 <= (13'(NOTE_PERIODS[n]) + 13'(NOTE_PERIODS[n+1]));
		end
	end

	// All flags set means the period is under every midpoint: top index.
	// Otherwise the first cleared flag marks the index; the edge is one-hot.
	always_comb begin
		note_idx = below_mid[MidCount-1] ? 7'(MidCount) : 7'd0;
		for (int n = 1; n < MidCount; n++) begin
			if (!below_mid[n] && below_mid[n-1]) begin
				note_idx = note_idx | 7'(n);
			end
		end
	end

	assign break_val = {1'b0, par_in[7:4], 3'b000} + {3'b000, par_in[7:4], 1'b0}
		+ {4'b0000, par_in[3:0]};

	always_comb begin
		cv  = 1'b1;
		cmd = CMD_A;
		par = par_in;
		result.volume_valid = 1'b0;
		result.volume       = 7'd0;
		unique case (effect)
			EFF_ARPEGGIO: begin
				if (par_in != 8'd0) cmd = CMD_J;
				else cv = 1'b0;
			end
			EFF_PORTA_UP:   cmd = CMD_F;
			EFF_PORTA_DN:   cmd = CMD_E;
			EFF_TONE_PORTA: cmd = CMD_G;
			EFF_VIBRATO:    cmd = CMD_H;
			EFF_TP_VOLSL:   cmd = CMD_L;
			EFF_VIB_VOLSL:  cmd = CMD_K;
			EFF_TREMOLO:    cmd = CMD_R;
			EFF_PANNING:    cmd = CMD_X;
			EFF_OFFSET:     cmd = CMD_O;
			EFF_VOL_SLIDE:  cmd = CMD_D;
			EFF_JUMP:       cmd = CMD_B;
			EFF_VOLUME: begin
				cv = 1'b0;
				result.volume_valid = 1'b1;
				result.volume = (par_in > VOLUME_MAX) ? VOLUME_MAX[6:0] : par_in[6:0];
			end
			EFF_BREAK: begin
				cmd = CMD_C;
				par = break_val;
			end
			EFF_EXTENDED: begin
				cmd = CMD_S;
				unique case (par_in[7:4])
					EXT_FINE_UP: begin
						cmd = CMD_F;
						par = PAR_FINE_HI | {4'h0, par_in[3:0]};
					end
					EXT_FINE_DN: begin
						cmd = CMD_E;
						par = PAR_FINE_HI | {4'h0, par_in[3:0]};
					end
					EXT_VIB_WAVE:  par = PAR_VIBWAVE | {6'd0, par_in[1:0]};
					EXT_LOOP:      par = PAR_LOOP | {4'h0, par_in[3:0]};
					EXT_TREM_WAVE: par = PAR_TREMWAVE | {6'd0, par_in[1:0]};
					EXT_PAN, EXT_CUT, EXT_DELAY: par = par_in;
					EXT_RETRIG: begin
						cmd = CMD_Q;
						par = {4'h0, par_in[3:0]};
					end
					EXT_FVOL_UP: begin
						cmd = CMD_D;
						par = {par_in[3:0], 4'hF};
					end
					EXT_FVOL_DN: begin
						cmd = CMD_D;
						par = PAR_FINE_HI | {4'h0, par_in[3:0]};
					end
					EXT_PAT_DELAY: par = PAR_PATDELAY | {4'h0, par_in[3:0]};
					EXT_FILTER, EXT_GLISS, EXT_FINETUNE, EXT_INVERT: cv = 1'b0;
					default: cv = 1'b0;
				endcase
			end
			EFF_SPEED: cmd = (par_in < SPEED_LIMIT) ? CMD_A : CMD_T;
			default: cmd = CMD_A;
		endcase

		result.command_valid = cv;
		result.command       = cv ? cmd : CMD_A;
		result.parameter_res = cv ? par : 8'd0;

		result.note_valid = (period != 12'd0) && (period != PERIOD_EMPTY_HI);
		result.note       = result.note_valid ? (note_idx + 7'(NoteBase)) : 7'd0;
		result.instrument_valid = sample != 8'd0;
		result.instrument = result.instrument_valid ? (sample - 8'd1) : 8'd0;
	end

endmodule

@@ rtl/core/mod_cell_effect_translate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mod_cell_effect_translate
// Pattern cell translator: one raw four-channel pattern cell word in, one
// set of tracker note fields out.
// ----------------------------------------------------------------------------
// Takes one cell request per clock while the output is not stalled. The
// cell word is captured in an input register, decoded by a single pass of
// combinational logic (71 parallel midpoint compares against the constant
// period table, a thermometer edge encode and the effect rewrite), and
// captured in the result register that drives the outputs. The sustained
// rate is one cell per cycle, set by that single decode pass.
// Each stage moves on when the stage after it is empty or being drained, so
// the input register still fills while a finished result waits on out_stall;
// in_stall rises only when both registers hold a request and the output is
// stalled. Fields whose valid flag is low read as zero.
// ----------------------------------------------------------------------------
module mod_cell_effect_translate (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] cell_word,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        note_valid,
	output logic [6:0]  note,
	output logic        instrument_valid,
	output logic [7:0]  instrument,
	output logic        command_valid,
	output logic [4:0]  command,
	output logic [7:0]  parameter_res,
	output logic        volume_valid,
	output logic [6:0]  volume
);
	import mcet_pkg::*;

	logic         valid_s1;
	logic [31:0]  cell_word_s1;
	logic         valid_s2;
	cell_result_t result_s2;
	cell_result_t decoded;
	logic         adv_s2;
	logic         adv_s1;

	// Advance the result register when it is empty or its request is taken;
	// advance the input register when it is empty or can hand over.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register: hold the cell word until the decoder result is captured.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			cell_word_s1 <= cell_word;
		end
	end

	mcet_decode u_decode (
		.cell_word (cell_word_s1),
		.result    (decoded)
	);

	// Result register: hold while stalled, otherwise take the next decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	assign out_valid        = valid_s2;
	assign note_valid       = result_s2.note_valid;
	assign note             = result_s2.note;
	assign instrument_valid = result_s2.instrument_valid;
	assign instrument       = result_s2.instrument;
	assign command_valid    = result_s2.command_valid;
	assign command          = result_s2.command;
	assign parameter_res    = result_s2.parameter_res;
	assign volume_valid     = result_s2.volume_valid;
	assign volume           = result_s2.volume;

	// Back-pressure only reaches the input when both stages are occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while pipeline has room");

	// An accepted request always lands in the input register.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted request lost");

	// A volume result never carries a command and stays within range.
	a_volume_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && volume_valid) |-> (!command_valid && volume <= 7'd64))
		else $error("volume result malformed");

	// Empty command fields read as zero.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !command_valid) |-> (command == 5'd0 && parameter_res == 8'd0))
		else $error("empty command carries data");

	// A note, when present, lies within the table's range.
	a_note_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && note_valid) |-> (note >= 7'd36 && note <= 7'd107))
		else $error("note out of range");

endmodule

@@ sim/tb_mod_cell_effect_translate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mod_cell_effect_translate
// Self-checking bench for the pattern cell translator. It first walks a table
// of hand-picked cells: empty and full words, period extremes, a nearest-entry
// tie, volume clamping, pattern-break conversion and every effect and extended
// sub-effect. It then sends about 1550 random cells, biased toward table
// periods, midpoints and the edges of the period range. Every result is checked
// field by field against hand-typed fields or an in-bench decoder. The input
// side idles and the output side stalls at random, except in one quiet stretch.
// ----------------------------------------------------------------------------
module tb_mod_cell_effect_translate;
	import mcet_pkg::*;

	localparam int DirectedRows = 37;
	localparam int RandomCells  = 1550;
	localparam int QuietFirst   = 700;
	localparam int QuietLast    = 999;
	localparam int IdlePercent  = 18;
	localparam int DrainCycles  = 8;
	localparam int StuckLimit   = 4000;

	// One row of the directed table; the result is typed in only when want_typed is set.
	typedef struct {
		logic [31:0]  word;
		bit           want_typed;
		cell_result_t want;
	} cell_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [31:0] cell_word = '0;
	logic        out_stall = 1'b0;

	logic       in_stall;
	logic       out_valid;
	logic       note_valid;
	logic [6:0] note;
	logic       instrument_valid;
	logic [7:0] instrument;
	logic       command_valid;
	logic [4:0] command;
	logic [7:0] parameter_res;
	logic       volume_valid;
	logic [6:0] volume;

	// Set during the quiet stretch: no idling on either side.
	bit no_gaps = 1'b0;

	// Decoded fields still owed by the block, oldest first.
	cell_result_t pending_results [$];

	int unsigned mismatches    = 0;
	int unsigned cells_sent    = 0;
	int unsigned results_seen  = 0;
	int unsigned notes_seen    = 0;
	int unsigned commands_seen = 0;
	int unsigned volumes_seen  = 0;
	int unsigned stuck_cycles  = 0;

	mod_cell_effect_translate u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cell_word        (cell_word),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.note_valid       (note_valid),
		.note             (note),
		.instrument_valid (instrument_valid),
		.instrument       (instrument),
		.command_valid    (command_valid),
		.command          (command),
		.parameter_res    (parameter_res),
		.volume_valid     (volume_valid),
		.volume           (volume)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Match a period to the nearest table entry. On a tie, take the shorter
	// period. Above the top entry the lowest note results, below the floor the highest.
	function automatic logic [6:0] period_note(logic [11:0] per);
		int idx;
		int gap_up;
		int gap_down;
		for (idx = 0; idx < PeriodCount; idx++) begin
			if (per >= NOTE_PERIODS[idx]) begin
				if (idx > 0 && per != NOTE_PERIODS[idx]) begin
					gap_up   = int'(NOTE_PERIODS[idx - 1]) - int'(per);
					gap_down = int'(per) - int'(NOTE_PERIODS[idx]);
					if (gap_up < gap_down)
						return 7'(idx + NoteBase - 1);
				end
				return 7'(idx + NoteBase);
			end
		end
		return 7'(PeriodCount + NoteBase - 1);
	endfunction

	// Decode one cell word into the fields the block should return.
	function automatic cell_result_t decode_cell(logic [31:0] w);
		cell_result_t r;
		logic [7:0]   smp;
		logic [7:0]   par;
		logic [11:0]  per;
		r   = '0;
		smp = {w[31:28], w[15:12]};
		per = w[27:16];
		par = w[7:0];

		if (per != 12'h000 && per != PERIOD_EMPTY_HI) begin
			r.note_valid = 1'b1;
			r.note       = period_note(per);
		end
		if (smp != 8'h00) begin
			r.instrument_valid = 1'b1;
			r.instrument       = smp - 8'd1;
		end

		r.command_valid = 1'b1;
		case (w[11:8])
			EFF_ARPEGGIO: begin
				if (par != 8'h00)
					r.command = CMD_J;
				else
					r.command_valid = 1'b0;
			end
			EFF_PORTA_UP:   r.command = CMD_F;
			EFF_PORTA_DN:   r.command = CMD_E;
			EFF_TONE_PORTA: r.command = CMD_G;
			EFF_VIBRATO:    r.command = CMD_H;
			EFF_TP_VOLSL:   r.command = CMD_L;
			EFF_VIB_VOLSL:  r.command = CMD_K;
			EFF_TREMOLO:    r.command = CMD_R;
			EFF_PANNING:    r.command = CMD_X;
			EFF_OFFSET:     r.command = CMD_O;
			EFF_VOL_SLIDE:  r.command = CMD_D;
			EFF_JUMP:       r.command = CMD_B;
			EFF_VOLUME: begin
				// Volume only, clamped; no command.
				r.command_valid = 1'b0;
				r.volume_valid  = 1'b1;
				r.volume        = (par > VOLUME_MAX) ? 7'(VOLUME_MAX) : 7'(par);
			end
			EFF_BREAK: begin
				// Row number is BCD: tens in the high nibble, which may exceed 9.
				r.command = CMD_C;
				par       = 8'(par[7:4] * 10 + par[3:0]);
			end
			EFF_EXTENDED: begin
				r.command = CMD_S;
				case (par[7:4])
					EXT_FINE_UP: begin
						r.command = CMD_F;
						par       = PAR_FINE_HI | {4'h0, par[3:0]};
					end
					EXT_FINE_DN: begin
						r.command = CMD_E;
						par       = PAR_FINE_HI | {4'h0, par[3:0]};
					end
					EXT_VIB_WAVE:  par = PAR_VIBWAVE | {6'h00, par[1:0]};
					EXT_LOOP:      par = PAR_LOOP | {4'h0, par[3:0]};
					EXT_TREM_WAVE: par = PAR_TREMWAVE | {6'h00, par[1:0]};
					EXT_PAN, EXT_CUT, EXT_DELAY: ;
					EXT_RETRIG: begin
						r.command = CMD_Q;
						par       = {4'h0, par[3:0]};
					end
					EXT_FVOL_UP: begin
						r.command = CMD_D;
						par       = {par[3:0], 4'hF};
					end
					EXT_FVOL_DN: begin
						r.command = CMD_D;
						par       = {4'hF, par[3:0]};
					end
					EXT_PAT_DELAY: par = PAR_PATDELAY | {4'h0, par[3:0]};
					EXT_FILTER, EXT_GLISS, EXT_FINETUNE, EXT_INVERT: r.command_valid = 1'b0;
				endcase
			end
			EFF_SPEED: r.command = (par < SPEED_LIMIT) ? CMD_A : CMD_T;
		endcase

		if (r.command_valid)
			r.parameter_res = par;
		else
			r.command = '0;
		return r;
	endfunction

	// Pack hand-read fields into a result record for the directed table.
	function automatic cell_result_t typed_cell(int nv, int nt, int iv, int ins,
	                                            int cv, int cmd, int par, int vv, int vol);
		return {1'(nv), 7'(nt), 1'(iv), 8'(ins), 1'(cv), 5'(cmd), 8'(par), 1'(vv), 7'(vol)};
	endfunction

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Offer one cell request: idle for a random gap, then hold the word until accepted.
	// On acceptance, queue the fields the block owes for it.
	task automatic send_cell(logic [31:0] w, bit want_typed, cell_result_t want);
		while (!no_gaps && $urandom_range(99) < IdlePercent) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		cell_word <= w;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(want_typed ? want : decode_cell(w));
		cells_sent++;
	endtask

	// Result side: check each accepted result against the oldest expectation.
	// Then pick the stall for the next cycle.
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("note_valid", want.note_valid, note_valid);
					check_field("note", want.note, note);
					check_field("instrument_valid", want.instrument_valid, instrument_valid);
					check_field("instrument", want.instrument, instrument);
					check_field("command_valid", want.command_valid, command_valid);
					check_field("command", want.command, command);
					check_field("parameter_res", want.parameter_res, parameter_res);
					check_field("volume_valid", want.volume_valid, volume_valid);
					check_field("volume", want.volume, volume);
					results_seen++;
					notes_seen    += want.note_valid;
					commands_seen += want.command_valid;
					volumes_seen  += want.volume_valid;
				end
			end
			out_stall <= !no_gaps && ($urandom_range(99) < IdlePercent);
		end
	end

	// Watchdog: end the run if neither side moves a request for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles = 0;
		end else if (arst_n) begin
			stuck_cycles++;
			if (stuck_cycles >= StuckLimit) begin
				$display("watchdog: no request moved in %0d cycles", StuckLimit);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		cell_row_t   directed_rows [DirectedRows];
		logic [31:0] w;
		logic [11:0] per;
		int          i;
		int          pick;
		int          idx;
		int          mid;

		// Word layout: sample hi | period | sample lo | effect | parameter.
		directed_rows = '{
			// Empty word, then every bit set: no note, instrument 254, tempo.
			'{32'h0000_0000, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 0, 0, 0)},
			'{32'hFFFF_FFFF, 1'b1, typed_cell(0, 0, 1, 254, 1, CMD_T, 255, 0, 0)},
			// Top table period, sample 1, arpeggio with zero parameter.
			'{32'h06B0_1000, 1'b1, typed_cell(1, 36, 1, 0, 0, 0, 0, 0, 0)},
			// Period past the top entry; volume at the clamp boundary.
			'{32'h0FFE_0C40, 1'b1, typed_cell(1, 36, 0, 0, 0, 0, 0, 1, 64)},
			// Below the table floor, and at the floor; volume clamped and not.
			'{32'h001B_0CFF, 1'b1, typed_cell(1, 107, 0, 0, 0, 0, 0, 1, 64)},
			'{32'h001C_0C3F, 1'b1, typed_cell(1, 107, 0, 0, 0, 0, 0, 1, 63)},
			// Pattern break BCD, plain and with both nibbles at maximum.
			'{32'h0001_0D99, 1'b1, typed_cell(1, 107, 0, 0, 1, CMD_C, 99, 0, 0)},
			// Period 1664 sits exactly between 1712 and 1616: the higher note wins.
			'{32'h0680_0DFF, 1'b1, typed_cell(1, 37, 0, 0, 1, CMD_C, 165, 0, 0)},
			// Speed just under the tempo threshold.
			'{32'hF000_FF1F, 1'b1, typed_cell(0, 0, 1, 254, 1, CMD_A, 31, 0, 0)},
			// Extended sub-effects that drop the command.
			'{32'h0000_0E0F, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 0, 0, 0)},
			'{32'h0000_0E3A, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 0, 0, 0)},
			'{32'h0000_0E55, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 0, 0, 0)},
			'{32'h0000_0EFF, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 0, 0, 0)},
			// Remaining effect nibbles, each with a different period and sample.
			'{32'h0358_0037, 1'b0, '0},
			'{32'h1100_2180, 1'b0, '0},
			'{32'h2064_3280, 1'b0, '0},
			'{32'h01AC_4380, 1'b0, '0},
			'{32'h003F_5480, 1'b0, '0},
			'{32'h0200_6580, 1'b0, '0},
			'{32'h0071_7680, 1'b0, '0},
			'{32'h0036_8780, 1'b0, '0},
			'{32'h0078_9880, 1'b0, '0},
			'{32'h0500_A980, 1'b0, '0},
			'{32'h0001_BA0F, 1'b0, '0},
			'{32'h0FFF_CB3F, 1'b0, '0},
			// Extended sub-effects that keep or rewrite the command.
			'{32'h3123_4E1A, 1'b0, '0},
			'{32'h0097_0E2B, 1'b0, '0},
			'{32'h5000_0E47, 1'b0, '0},
			'{32'h00F1_1E6C, 1'b0, '0},
			'{32'h0020_0E7E, 1'b0, '0},
			'{32'h0400_2E85, 1'b0, '0},
			'{32'h0032_0E93, 1'b0, '0},
			'{32'h7123_0EA4, 1'b0, '0},
			'{32'h0055_3EB6, 1'b0, '0},
			'{32'h0AAA_0EC2, 1'b0, '0},
			'{32'h0029_5ED8, 1'b0, '0},
			'{32'h0555_0EE9, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DirectedRows; i++)
			send_cell(directed_rows[i].word, directed_rows[i].want_typed, directed_rows[i].want);

		for (i = 0; i < RandomCells; i++) begin
			no_gaps = (i >= QuietFirst && i <= QuietLast);
			w    = $urandom;
			pick = $urandom_range(99);
			idx  = $urandom_range(PeriodCount - 2);
			// Bias the period toward exact entries, midpoints and the ends of the range.
			if (pick < 30) begin
				per = NOTE_PERIODS[idx];
			end else if (pick < 55) begin
				mid = (int'(NOTE_PERIODS[idx]) + int'(NOTE_PERIODS[idx + 1])) / 2;
				per = 12'(mid + int'($urandom_range(2)) - 1);
			end else if (pick < 65) begin
				per = 12'($urandom_range(27));
			end else if (pick < 72) begin
				per = 12'($urandom_range(4095, 1712));
			end else if (pick < 80) begin
				per = pick[0] ? PERIOD_EMPTY_HI : 12'h000;
			end else begin
				per = w[27:16];
			end
			w[27:16] = per;
			if ($urandom_range(9) == 0)
				{w[31:28], w[15:12]} = 8'h00;
			// Small parameters land near the tempo and volume thresholds.
			if ($urandom_range(3) == 0)
				w[7:0] = 8'($urandom_range(70));
			send_cell(w, 1'b0, '0);
		end
		no_gaps = 1'b0;

		// Drop valid and drain what is still owed, then watch for strays.
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("sent %0d cells (%0d table rows), checked %0d results", cells_sent,
		         DirectedRows, results_seen);
		$display("results carried %0d notes, %0d commands, %0d volumes", notes_seen,
		         commands_seen, volumes_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
